@@ rtl/lad_pkg.sv @@
// Package for the linear array deque: sizes, codes, item and control types.
`timescale 1ns / 1ps
`default_nettype none
package lad_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W  = 32;
    localparam int OCC_W   = 5;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] popped_value;
        logic [OCC_W-1:0]         occupancy;
        logic                     now_empty;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic needs_read;
    } sts_t;

endpackage
`default_nettype wire

@@ rtl/linear_array_deque.sv @@
// Top level of the linear array deque: controller, datapath and checks.
`timescale 1ns / 1ps
`default_nettype none
// A double-ended queue kept in a plain, non-circular store of lad_pkg::DEPTH
// slots. Each input item is one op (push front, push back, pop front, pop
// back) and yields exactly one result item with a status, the popped value,
// the occupancy and an empty flag. One item is in flight at a time: the
// result of a push or a failed op is valid in the state after the execute
// state, that of a successful pop only after a further read state, which
// waits for the registered read of the element RAM. The next item is
// accepted in the cycle after the result is taken. The input is not ready
// during reset.
module linear_array_deque (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire lad_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output lad_pkg::out_item_t      m_data
);

    lad_pkg::cmd_t cmd;
    lad_pkg::sts_t sts;

    lad_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lad_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while a result is pending");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !m_valid)
        else $error("block not busy after accepting an item");

    a_empty_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.now_empty |-> m_data.occupancy == '0)
        else $error("empty deque reports nonzero occupancy");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != lad_pkg::ST_OK) |-> m_data.popped_value == '0)
        else $error("failed op reports a popped value");

endmodule
`default_nettype wire

@@ rtl/lad_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/lad_ctrl.sv @@
// Controller state machine: sequences accept, update, read and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module lad_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    input  wire lad_pkg::sts_t sts,
    output lad_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd.load    = 1'b0;
        cmd.exec    = 1'b0;
        cmd.capture = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.needs_read ? S_READ : S_RESP;
            end
            S_READ: begin
                cmd.capture = 1'b1;
                state_next  = S_RESP;
            end
            S_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/lad_dp.sv @@
// Datapath: end indices, empty flag, element store and result registers.
`timescale 1ns / 1ps
`default_nettype none
module lad_dp (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lad_pkg::in_item_t s_data,
    input  wire lad_pkg::cmd_t     cmd,
    output lad_pkg::sts_t          sts,
    output lad_pkg::out_item_t     m_data
);

    lad_pkg::op_t                       op_reg;
    logic signed [lad_pkg::DATA_W-1:0]  value_reg;
    logic [lad_pkg::IDX_W-1:0]          head_reg, head_next;
    logic [lad_pkg::IDX_W-1:0]          tail_reg, tail_next;
    logic                               empty_reg, empty_next;
    logic [1:0]                         status_reg, status_next;
    logic [lad_pkg::DATA_W-1:0]         popped_reg, popped_next;
    logic                               is_pop;
    logic                               ram_we;
    logic                               ram_re;
    logic [lad_pkg::IDX_W-1:0]          ram_waddr;
    logic [lad_pkg::IDX_W-1:0]          ram_raddr;
    logic [lad_pkg::DATA_W-1:0]         ram_rdata;
    logic [lad_pkg::IDX_W:0]            occ_full;

    lad_ram #(
        .WIDTH (lad_pkg::DATA_W),
        .DEPTH (lad_pkg::DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign is_pop = (op_reg == lad_pkg::OP_POP_FRONT) || (op_reg == lad_pkg::OP_POP_BACK);
    assign sts.needs_read = is_pop && !empty_reg;
    assign ram_raddr = (op_reg == lad_pkg::OP_POP_FRONT) ? head_reg : tail_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_data.op;
            value_reg <= s_data.value;
        end
        status_reg <= status_next;
        popped_reg <= popped_next;
    end

    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        status_next = status_reg;
        popped_next = popped_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = head_reg;
        if (cmd.exec) begin
            status_next = lad_pkg::ST_OK;
            popped_next = '0;
            case (op_reg)
                lad_pkg::OP_PUSH_FRONT: begin
                    if (empty_reg) begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b0;
                        ram_waddr  = '0;
                        ram_we     = 1'b1;
                    end else if (head_reg != '0) begin
                        head_next = lad_pkg::IDX_W'(head_reg - 1'b1);
                        ram_waddr = lad_pkg::IDX_W'(head_reg - 1'b1);
                        ram_we    = 1'b1;
                    end else begin
                        status_next = lad_pkg::ST_OVERFLOW;
                    end
                end
                lad_pkg::OP_PUSH_BACK: begin
                    if (empty_reg) begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b0;
                        ram_waddr  = '0;
                        ram_we     = 1'b1;
                    end else if (tail_reg != lad_pkg::IDX_LAST) begin
                        tail_next = lad_pkg::IDX_W'(tail_reg + 1'b1);
                        ram_waddr = lad_pkg::IDX_W'(tail_reg + 1'b1);
                        ram_we    = 1'b1;
                    end else begin
                        status_next = lad_pkg::ST_OVERFLOW;
                    end
                end
                lad_pkg::OP_POP_FRONT, lad_pkg::OP_POP_BACK: begin
                    if (empty_reg) begin
                        status_next = lad_pkg::ST_EMPTY;
                    end else begin
                        ram_re = 1'b1;
                        if (head_reg >= tail_reg) begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b1;
                        end else if (op_reg == lad_pkg::OP_POP_FRONT) begin
                            head_next = lad_pkg::IDX_W'(head_reg + 1'b1);
                        end else begin
                            tail_next = lad_pkg::IDX_W'(tail_reg - 1'b1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (cmd.capture) begin
            popped_next = ram_rdata;
        end
    end

    assign occ_full = {1'b0, tail_reg} - {1'b0, head_reg} + 1'b1;

    always_comb begin
        m_data.status       = status_reg;
        m_data.popped_value = popped_reg;
        m_data.occupancy    = empty_reg ? '0 : lad_pkg::OCC_W'(occ_full);
        m_data.now_empty    = empty_reg;
    end

endmodule
`default_nettype wire
